// File: design/pgcm_pkg.sv
// Package for the pixel grey and color mask block.
// Holds pixel struct types, register indexes, mode codes and fixed-point constants.
// No dependencies.
package pgcm_pkg;

  // Input item: one pixel of up to four channels
  typedef struct packed {
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
    logic [7:0] chan_alpha;
    logic       last_pixel;
  } in_pixel_t;

  // Result item: processed pixel plus error flag
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_last;
    logic       too_few_channels;
  } out_pixel_t;

  // Configuration register file contents
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  channel_count;
    logic [11:0] gain_red;
    logic [11:0] gain_green;
    logic [11:0] gain_blue;
  } cfg_regs_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CHAN_COUNT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_RED   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN_GREEN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAIN_BLUE  = 3'd4;

  // Mode codes (code 3 passes the pixel through)
  localparam logic [1:0] MODE_AVG  = 2'd0;
  localparam logic [1:0] MODE_LUMA = 2'd1;
  localparam logic [1:0] MODE_MASK = 2'd2;

  // Reset values
  localparam logic [2:0]  CHAN_COUNT_RST = 3'd3;
  localparam logic [11:0] GAIN_UNITY     = 12'd256;
  localparam logic [2:0]  MIN_CHANNELS   = 3'd3;

  // BT.709 luma weights in Q0.16, summing to exactly 65536
  localparam logic [15:0] LUMA_COEF_R = 16'd13933;
  localparam logic [15:0] LUMA_COEF_G = 16'd46871;
  localparam logic [15:0] LUMA_COEF_B = 16'd4732;

  // Divide by three: floor(s/3) == (s * 683) >> 11 for every s up to 765
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int         DIV3_SHIFT = 11;

endpackage

// File: design/pixel_grey_and_color_mask.sv
// Top level of the pixel grey and color mask block: input register, datapath, result register.
// Depends on pgcm_pkg, pgcm_cfg and pgcm_alu.
//
//  channel  ports                          handshake
//  input    start, busy, in_pix            taken when start && !busy
//  result   out_valid, out_pix             one-cycle strobe, always taken
//  config   cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// One item per clock; each result passes through the input register and then the
// result register. busy stays low: the datapath is a single registered pass with
// no shared unit. Reset is synchronous on rst_n and clears the valid bits and the
// configuration registers. The receiver cannot stall.
module pixel_grey_and_color_mask import pgcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_pixel_t           in_pix,
  output logic                out_valid,
  output out_pixel_t          out_pix,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_regs_t  cfg;
  in_pixel_t  in_pix_r;
  logic       in_vld_r;
  out_pixel_t res;
  out_pixel_t out_pix_r;
  logic       out_valid_r;
  logic       accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pgcm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_pix_r <= in_pix;
    end
  end

  pgcm_alu u_alu (
    .pix_i (in_pix_r),
    .cfg_i (cfg),
    .pix_o (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_pix_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  // Every taken item gives a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result strobe missing two cycles after an item");

  // A result strobe always comes from a taken item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result strobe without an item");

  // Alpha and end marker travel untouched
  a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pix.out_alpha == $past(in_pix.chan_alpha, 2))
                  && (out_pix.out_last == $past(in_pix.last_pixel, 2)))
    else $error("alpha or end marker altered");

  // Channel count error leaves the color channels as they came in
  a_err_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pix.too_few_channels) |->
      (out_pix.out_red == $past(in_pix.chan_red, 2))
      && (out_pix.out_green == $past(in_pix.chan_green, 2))
      && (out_pix.out_blue == $past(in_pix.chan_blue, 2)))
    else $error("pixel changed despite channel count error");

  // Grey modes write one value to all three channels
  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pix.too_few_channels
      && (cfg.mode == MODE_AVG || cfg.mode == MODE_LUMA)) |->
      (out_pix.out_red == out_pix.out_green) && (out_pix.out_green == out_pix.out_blue))
    else $error("grey result differs between channels");

endmodule

// File: design/pgcm_cfg.sv
// Configuration register file for the pixel grey and color mask block.
// Depends on pgcm_pkg for the register struct, indexes and reset values.
module pgcm_cfg import pgcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_regs_t           cfg_o
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       regs_nxt.mode          = cfg_data[1:0];
        REG_CHAN_COUNT: regs_nxt.channel_count = cfg_data[2:0];
        REG_GAIN_RED:   regs_nxt.gain_red      = cfg_data;
        REG_GAIN_GREEN: regs_nxt.gain_green    = cfg_data;
        REG_GAIN_BLUE:  regs_nxt.gain_blue     = cfg_data;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.mode          <= MODE_AVG;
      regs_r.channel_count <= CHAN_COUNT_RST;
      regs_r.gain_red      <= GAIN_UNITY;
      regs_r.gain_green    <= GAIN_UNITY;
      regs_r.gain_blue     <= GAIN_UNITY;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_o = regs_r;

endmodule

// File: design/pgcm_alu.sv
// Pixel datapath: average grey, BT.709 luma grey, per-channel gain mask or pass-through.
// Pure combinational; depends on pgcm_pkg for types, mode codes and constants.
module pgcm_alu import pgcm_pkg::*; (
  input  in_pixel_t  pix_i,
  input  cfg_regs_t  cfg_i,
  output out_pixel_t pix_o
);

  logic [9:0]  sum_rgb;
  logic [19:0] avg_prod;
  logic [7:0]  avg_grey;
  logic [23:0] luma_acc;
  logic [7:0]  luma_grey;
  logic [19:0] prod_r, prod_g, prod_b;
  logic [7:0]  mask_r, mask_g, mask_b;
  logic        err;

  // Average: sum then divide by three through the reciprocal
  assign sum_rgb  = {2'b0, pix_i.chan_red} + {2'b0, pix_i.chan_green}
                  + {2'b0, pix_i.chan_blue};
  assign avg_prod = {10'b0, sum_rgb} * {10'b0, DIV3_RECIP};
  assign avg_grey = avg_prod[DIV3_SHIFT +: 8];

  // Luma: constant weights, sum never exceeds 255 << 16
  assign luma_acc = {8'b0, pix_i.chan_red}   * {8'b0, LUMA_COEF_R}
                  + {8'b0, pix_i.chan_green} * {8'b0, LUMA_COEF_G}
                  + {8'b0, pix_i.chan_blue}  * {8'b0, LUMA_COEF_B};
  assign luma_grey = luma_acc[23:16];

  // Gain mask: Q4.8 product, drop fraction, clamp at 255
  assign prod_r = {12'b0, pix_i.chan_red}   * {8'b0, cfg_i.gain_red};
  assign prod_g = {12'b0, pix_i.chan_green} * {8'b0, cfg_i.gain_green};
  assign prod_b = {12'b0, pix_i.chan_blue}  * {8'b0, cfg_i.gain_blue};
  assign mask_r = (prod_r[19:16] != 4'd0) ? 8'hFF : prod_r[15:8];
  assign mask_g = (prod_g[19:16] != 4'd0) ? 8'hFF : prod_g[15:8];
  assign mask_b = (prod_b[19:16] != 4'd0) ? 8'hFF : prod_b[15:8];

  assign err = (cfg_i.channel_count < MIN_CHANNELS);

  // Select by mode; channel count error forces pass-through
  always_comb begin
    pix_o.out_red          = pix_i.chan_red;
    pix_o.out_green        = pix_i.chan_green;
    pix_o.out_blue         = pix_i.chan_blue;
    pix_o.out_alpha        = pix_i.chan_alpha;
    pix_o.out_last         = pix_i.last_pixel;
    pix_o.too_few_channels = err;
    if (!err) begin
      unique case (cfg_i.mode)
        MODE_AVG: begin
          pix_o.out_red   = avg_grey;
          pix_o.out_green = avg_grey;
          pix_o.out_blue  = avg_grey;
        end
        MODE_LUMA: begin
          pix_o.out_red   = luma_grey;
          pix_o.out_green = luma_grey;
          pix_o.out_blue  = luma_grey;
        end
        MODE_MASK: begin
          pix_o.out_red   = mask_r;
          pix_o.out_green = mask_g;
          pix_o.out_blue  = mask_b;
        end
        default: begin
          pix_o.out_red   = pix_i.chan_red;
          pix_o.out_green = pix_i.chan_green;
          pix_o.out_blue  = pix_i.chan_blue;
        end
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the pixel grey and color mask block.
// Depends on pgcm_pkg (pixel structs, register indexes, mode codes) and the
// top-level RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pgcm_pkg::*;

  // Mode code with no operation: the pixel passes through
  localparam logic [1:0] MODE_PASS = 2'd3;
  // First register index that maps to nothing
  localparam int FIRST_UNUSED_REG = REG_GAIN_BLUE + 1;
  localparam int LAST_REG_INDEX   = (1 << CfgIdxW) - 1;
  localparam int CYCLE_LIMIT      = 100000;
  localparam int SEGMENT_ITEMS    = 50;
  localparam int SEGMENTS         = 10;

  // Pixel processing predictor and result store
  class pixel_scoreboard;
    // BT.709 weights in Q0.16
    localparam int unsigned WEIGHT_R = 13933;
    localparam int unsigned WEIGHT_G = 46871;
    localparam int unsigned WEIGHT_B = 4732;

    logic [1:0]  mode_q;
    logic [2:0]  chan_count_q;
    logic [11:0] gain_red_q;
    logic [11:0] gain_green_q;
    logic [11:0] gain_blue_q;
    out_pixel_t  expected_q[$];
    int          fails;

    function new();
      mode_q       = MODE_AVG;
      chan_count_q = CHAN_COUNT_RST;
      gain_red_q   = GAIN_UNITY;
      gain_green_q = GAIN_UNITY;
      gain_blue_q  = GAIN_UNITY;
      fails        = 0;
    endfunction

    // Register write; unused indexes change nothing
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_MODE:       mode_q       = data[1:0];
        REG_CHAN_COUNT: chan_count_q = data[2:0];
        REG_GAIN_RED:   gain_red_q   = data;
        REG_GAIN_GREEN: gain_green_q = data;
        REG_GAIN_BLUE:  gain_blue_q  = data;
        default: ;
      endcase
    endfunction

    // Q4.8 gain with truncation and saturation at 255
    function logic [7:0] apply_gain(logic [7:0] sample, logic [11:0] gain);
      logic [19:0] prod;
      prod = sample * gain;
      return (prod[19:8] > 12'd255) ? 8'hFF : prod[15:8];
    endfunction

    function out_pixel_t predict(in_pixel_t p);
      logic [9:0]  sum;
      logic [25:0] luma;
      logic [7:0]  grey;
      out_pixel_t  o;
      o.out_red          = p.chan_red;
      o.out_green        = p.chan_green;
      o.out_blue         = p.chan_blue;
      o.out_alpha        = p.chan_alpha;
      o.out_last         = p.last_pixel;
      o.too_few_channels = 1'b0;
      if (chan_count_q < 3'd3) begin
        o.too_few_channels = 1'b1;
      end else begin
        case (mode_q)
          MODE_AVG: begin
            sum  = p.chan_red + p.chan_green + p.chan_blue;
            grey = 8'(sum / 10'd3);
            o.out_red = grey; o.out_green = grey; o.out_blue = grey;
          end
          MODE_LUMA: begin
            luma = 26'(WEIGHT_R * p.chan_red + WEIGHT_G * p.chan_green
                       + WEIGHT_B * p.chan_blue);
            grey = luma[23:16];
            o.out_red = grey; o.out_green = grey; o.out_blue = grey;
          end
          MODE_MASK: begin
            o.out_red   = apply_gain(p.chan_red, gain_red_q);
            o.out_green = apply_gain(p.chan_green, gain_green_q);
            o.out_blue  = apply_gain(p.chan_blue, gain_blue_q);
          end
          default: ;
        endcase
      end
      return o;
    endfunction

    function void note_pixel(in_pixel_t p);
      expected_q.push_back(predict(p));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_pixel(out_pixel_t got);
      out_pixel_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_red", want.out_red, got.out_red);
      compare_field("out_green", want.out_green, got.out_green);
      compare_field("out_blue", want.out_blue, got.out_blue);
      compare_field("out_alpha", want.out_alpha, got.out_alpha);
      compare_field("out_last", 8'(want.out_last), 8'(got.out_last));
      compare_field("too_few_channels", 8'(want.too_few_channels),
                    8'(got.too_few_channels));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_pixel_t           in_pix;
  logic                out_valid;
  out_pixel_t          out_pix;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  cycle_count;

  pixel_scoreboard sb = new();

  pixel_grey_and_color_mask DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pix    (in_pix),
    .out_valid (out_valid),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note accepted items and check results at each edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_pixel(in_pix);
    if (rst_n && out_valid) sb.check_pixel(out_pix);
  end

  // Run limit
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("** pixel_grey_and_color_mask: FAILED **");
    $finish;
  end

  function in_pixel_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [7:0] a, logic last);
    in_pixel_t p;
    p.chan_red   = r;
    p.chan_green = g;
    p.chan_blue  = b;
    p.chan_alpha = a;
    p.last_pixel = last;
    return p;
  endfunction

  function in_pixel_t random_pixel();
    return make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 15) == 0);
  endfunction

  // Gains lean toward zero, unity and full scale
  function logic [11:0] random_gain();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return GAIN_UNITY;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // One register write, then the enable drops
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random gap, then hold start until the item is taken
  task automatic send_pixel(in_pixel_t p, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_pix <= p;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Random settings; upper data bits are random to exercise masking
  task automatic random_config();
    logic [CfgDataW-1:0] data;
    data      = CfgDataW'($urandom);
    data[1:0] = 2'($urandom_range(0, 3));
    write_reg(REG_MODE, data);
    data      = CfgDataW'($urandom);
    data[2:0] = 3'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 2)
                                              : $urandom_range(3, 7));
    write_reg(REG_CHAN_COUNT, data);
    write_reg(REG_GAIN_RED, random_gain());
    write_reg(REG_GAIN_GREEN, random_gain());
    write_reg(REG_GAIN_BLUE, random_gain());
    if ($urandom_range(0, 3) == 0)
      write_reg(CfgIdxW'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)),
                CfgDataW'($urandom));
  endtask

  initial begin
    int idle_pct;
    start     <= 1'b0;
    in_pix    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: average grey over three channels
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1), 0);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd254, 8'h5A, 1'b0), 0);
    send_pixel(make_pixel(8'd1, 8'd1, 8'd0, 8'hA5, 1'b0), 0);

    // Luminance grey, full-scale and single-channel pixels
    wait_drained();
    write_reg(REG_MODE, CfgDataW'(MODE_LUMA));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd1, 1'b0), 0);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd2, 1'b0), 0);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd3, 1'b0), 0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 8'd4, 1'b1), 0);

    // Color mask with full-scale, zero and unity gains, saturation included
    wait_drained();
    write_reg(REG_MODE, CfgDataW'(MODE_MASK));
    write_reg(REG_GAIN_RED, 12'hFFF);
    write_reg(REG_GAIN_GREEN, 12'd0);
    write_reg(REG_GAIN_BLUE, GAIN_UNITY);
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0), 0);
    send_pixel(make_pixel(8'd1, 8'd16, 8'd200, 8'd0, 1'b1), 0);
    wait_drained();
    write_reg(REG_GAIN_RED, 12'd384);
    write_reg(REG_GAIN_GREEN, 12'd3000);
    write_reg(REG_GAIN_BLUE, 12'hFFF);
    send_pixel(make_pixel(8'd170, 8'd22, 8'h80, 8'h7F, 1'b0), 0);
    send_pixel(make_pixel(8'd15, 8'd255, 8'd0, 8'h80, 1'b0), 0);

    // Undefined mode passes the pixel through
    wait_drained();
    write_reg(REG_MODE, CfgDataW'(MODE_PASS));
    send_pixel(make_pixel(8'd12, 8'd34, 8'd56, 8'd78, 1'b1), 0);

    // Too few channels, under every count below three
    wait_drained();
    write_reg(REG_MODE, CfgDataW'(MODE_LUMA));
    for (int cc = 0; cc < 3; cc++) begin
      write_reg(REG_CHAN_COUNT, CfgDataW'(cc));
      send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'd25, cc[0]), 0);
      wait_drained();
    end

    // Counts of four and above process normally
    write_reg(REG_MODE, CfgDataW'(MODE_AVG));
    write_reg(REG_CHAN_COUNT, 12'd7);
    send_pixel(make_pixel(8'd10, 8'd20, 8'd31, 8'd40, 1'b0), 0);
    wait_drained();
    write_reg(REG_CHAN_COUNT, 12'd4);
    send_pixel(make_pixel(8'd250, 8'd3, 8'd7, 8'd9, 1'b0), 0);

    // A write to an unused index must not disturb the settings
    wait_drained();
    write_reg(CfgIdxW'(LAST_REG_INDEX), 12'hFFF);
    write_reg(CfgIdxW'(FIRST_UNUSED_REG), 12'h000);
    send_pixel(make_pixel(8'd99, 8'd100, 8'd101, 8'd102, 1'b1), 0);

    // Random segments, each under fresh settings and one of three idle rates
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < 3) ? 24 : (seg < 6) ? 82 : 0;
      wait_drained();
      random_config();
      repeat (SEGMENT_ITEMS) send_pixel(random_pixel(), idle_pct);
    end

    wait_drained();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("** pixel_grey_and_color_mask: PASSED **");
    end else begin
      $display("** pixel_grey_and_color_mask: FAILED **");
    end
    $finish;
  end

endmodule
